### hw/rtl/swept_box_collision_test_macros.svh
// Assertion macros shared by the swept box collision test RTL.
`ifndef SWEPT_BOX_COLLISION_TEST_MACROS_SVH
`define SWEPT_BOX_COLLISION_TEST_MACROS_SVH

// same-cycle implication, reset masked
`define SBC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define SBC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/sbc_pkg.sv
// Shared constants for the swept box collision test.
`default_nettype none
package sbc_pkg;
	localparam logic signed [1:0] NRM_NEG  = 2'sb11;
	localparam logic signed [1:0] NRM_ZERO = 2'sb00;
	localparam logic signed [1:0] NRM_POS  = 2'sb01;
	localparam int DIV_GUARD = 3;
endpackage
`default_nettype wire

### hw/rtl/swept_box_collision_test.sv
// Swept box collision test: one box pair per beat, pipelined restoring dividers.
// Accepts one box pair per clock whenever the result side is not stalled. Each beat
// passes from input to result through one stage for the swept box and edge gaps, one
// for magnitudes, one for the divider range check, one restoring divider step per quotient
// bit (TIME_FRAC+3 of them, four lanes side by side), then saturation, time compare and
// the result register. A stall on the result side holds the whole pipeline; no reset
// clearing pass is needed.
`default_nettype none
`include "swept_box_collision_test_macros.svh"
module swept_box_collision_test
	import sbc_pkg::*;
#(
	parameter int COORD_BITS = 24,
	parameter int TIME_FRAC  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic signed [COORD_BITS-1:0]   mov_left,
	input  logic signed [COORD_BITS-1:0]   mov_top,
	input  logic signed [COORD_BITS-1:0]   mov_right,
	input  logic signed [COORD_BITS-1:0]   mov_bottom,
	input  logic signed [COORD_BITS-1:0]   disp_x,
	input  logic signed [COORD_BITS-1:0]   disp_y,
	input  logic signed [COORD_BITS-1:0]   fix_left,
	input  logic signed [COORD_BITS-1:0]   fix_top,
	input  logic signed [COORD_BITS-1:0]   fix_right,
	input  logic signed [COORD_BITS-1:0]   fix_bottom,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic                           hit,
	output logic [TIME_FRAC:0]             entry_time,
	output logic signed [1:0]              normal_x,
	output logic signed [1:0]              normal_y
);
	localparam int CB = COORD_BITS;
	localparam int GW = CB + 1;
	localparam int QW = TIME_FRAC + DIV_GUARD;
	localparam int TW = TIME_FRAC + 3;
	localparam int NV = QW + 6;
	localparam logic [QW:0] TSAT_Q = (QW+1)'(1) << (TIME_FRAC + 1);
	localparam logic signed [TW-1:0] TSAT_T = TW'(TSAT_Q);
	localparam logic signed [TW-1:0] TONE_T = TW'(1) <<< TIME_FRAC;

	typedef struct packed {
		logic bp_ok;
		logic still_x;
		logic still_y;
		logic dx_pos;
		logic dy_pos;
	} ctl_t;

	typedef struct packed {
		logic [CB-1:0] rem;
		logic [QW-1:0] quo;
		logic [QW-1:0] sh;
		logic [CB-1:0] dv;
		logic          neg;
		logic          gnz;
		logic          ovf;
	} lane_t;

	logic en;
	logic [NV-1:0] vld_q;

	ctl_t                   ctl_s1, ctl_s2, ctl_tm, ctl_cm;
	ctl_t                   ctl_sd [QW+1];
	logic signed [GW-1:0]   gap_s1 [4];
	logic signed [CB-1:0]   dx_s1, dy_s1;
	logic [GW-1:0]          g_s2 [4];
	logic [CB-1:0]          d_s2 [4];
	logic                   neg_s2 [4];
	lane_t                  lane_sd [QW+1][4];
	logic signed [TW-1:0]   t_tm [4];
	logic                   ok_cm, xgt_cm;
	logic signed [TW-1:0]   te_cm, tx_cm;

	logic signed [GW-1:0] ml, mt, mr, mb, dx, dy, sl, st, sr, sb;
	logic signed [GW-1:0] bl, bt, br, bb;
	logic dxp, dyp, dxz, dyz;
	logic signed [GW-1:0] gap_c [4];

	assign en = !vld_q[NV-1] || res_ready;
	assign item_ready = en;
	assign res_valid = vld_q[NV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NV-2:0], item_valid};
		end
	end

	// front: swept box, broad phase, edge gaps
	always_comb begin
		ml = GW'(mov_left);
		mt = GW'(mov_top);
		mr = GW'(mov_right);
		mb = GW'(mov_bottom);
		dx = GW'(disp_x);
		dy = GW'(disp_y);
		sl = GW'(fix_left);
		st = GW'(fix_top);
		sr = GW'(fix_right);
		sb = GW'(fix_bottom);
		dxz = disp_x == '0;
		dyz = disp_y == '0;
		dxp = !disp_x[CB-1] && !dxz;
		dyp = !disp_y[CB-1] && !dyz;
		bl = dxp ? ml : ml + dx;
		bt = dyp ? mt : mt + dy;
		br = dxp ? mr + dx : mr;
		bb = dyp ? mb + dy : mb;
		gap_c[0] = dxp ? sl - mr : sr - ml;
		gap_c[1] = dxp ? sr - ml : sl - mr;
		gap_c[2] = dyp ? st - mb : sb - mt;
		gap_c[3] = dyp ? sb - mt : st - mb;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1.bp_ok   <= !(br < sl || bl > sr || bb < st || bt > sb);
			ctl_s1.still_x <= dxz;
			ctl_s1.still_y <= dyz;
			ctl_s1.dx_pos  <= dxp;
			ctl_s1.dy_pos  <= dyp;
			gap_s1         <= gap_c;
			dx_s1          <= disp_x;
			dy_s1          <= disp_y;
		end
	end

	// magnitudes and quotient sign
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2 <= ctl_s1;
			for (int i = 0; i < 4; i++) begin
				g_s2[i] <= gap_s1[i][GW-1] ? GW'(-gap_s1[i]) : GW'(gap_s1[i]);
				if (i < 2) begin
					d_s2[i]   <= dx_s1[CB-1] ? CB'(-dx_s1) : CB'(dx_s1);
					neg_s2[i] <= gap_s1[i][GW-1] ^ dx_s1[CB-1];
				end else begin
					d_s2[i]   <= dy_s1[CB-1] ? CB'(-dy_s1) : CB'(dy_s1);
					neg_s2[i] <= gap_s1[i][GW-1] ^ dy_s1[CB-1];
				end
			end
		end
	end

	// divider range check and seed
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_sd[0] <= ctl_s2;
			for (int i = 0; i < 4; i++) begin
				lane_sd[0][i].rem <= CB'(g_s2[i][GW-1:DIV_GUARD]);
				lane_sd[0][i].ovf <= CB'(g_s2[i][GW-1:DIV_GUARD]) >= d_s2[i];
				lane_sd[0][i].quo <= '0;
				lane_sd[0][i].sh  <= {g_s2[i][DIV_GUARD-1:0], {TIME_FRAC{1'b0}}};
				lane_sd[0][i].dv  <= d_s2[i];
				lane_sd[0][i].neg <= neg_s2[i];
				lane_sd[0][i].gnz <= g_s2[i] != '0;
			end
		end
	end

	// one restoring step per stage
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [CB-1:0] trial [4];
		logic          ge [4];

		always_comb begin
			for (int i = 0; i < 4; i++) begin
				trial[i] = {lane_sd[k][i].rem[CB-2:0], lane_sd[k][i].sh[QW-1]};
				ge[i]    = trial[i] >= lane_sd[k][i].dv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_sd[k+1] <= ctl_sd[k];
				for (int i = 0; i < 4; i++) begin
					lane_sd[k+1][i].dv  <= lane_sd[k][i].dv;
					lane_sd[k+1][i].neg <= lane_sd[k][i].neg;
					lane_sd[k+1][i].gnz <= lane_sd[k][i].gnz;
					lane_sd[k+1][i].ovf <= lane_sd[k][i].ovf;
					lane_sd[k+1][i].rem <= ge[i] ? trial[i] - lane_sd[k][i].dv : trial[i];
					lane_sd[k+1][i].quo <= {lane_sd[k][i].quo[QW-2:0], ge[i]};
					lane_sd[k+1][i].sh  <= lane_sd[k][i].sh << 1;
				end
			end
		end
	end

	// floor, saturate, sign, still axes
	logic [QW:0]          mag_c [4];
	logic signed [TW-1:0] tv_c [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag_c[i] = (QW+1)'(lane_sd[QW][i].quo) + (QW+1)'(lane_sd[QW][i].neg
				&& lane_sd[QW][i].gnz && lane_sd[QW][i].rem != '0);
			if (lane_sd[QW][i].ovf || mag_c[i] > TSAT_Q) begin
				mag_c[i] = TSAT_Q;
			end
			tv_c[i] = lane_sd[QW][i].neg ? -TW'(mag_c[i]) : TW'(mag_c[i]);
		end
		if (ctl_sd[QW].still_x) begin
			tv_c[0] = -(TSAT_T + TW'(2));
			tv_c[1] = TSAT_T + TW'(2);
		end
		if (ctl_sd[QW].still_y) begin
			tv_c[2] = -(TSAT_T + TW'(1));
			tv_c[3] = TSAT_T + TW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_tm <= ctl_sd[QW];
			t_tm   <= tv_c;
		end
	end

	// latest entry, earliest exit
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_cm <= ctl_tm;
			ok_cm  <= ctl_tm.bp_ok && !(ctl_tm.still_x && ctl_tm.still_y)
				&& !((t_tm[0] < 0 && t_tm[2] < 0) || t_tm[0] > TONE_T || t_tm[2] > TONE_T);
			xgt_cm <= t_tm[0] > t_tm[2];
			te_cm  <= (t_tm[0] > t_tm[2]) ? t_tm[0] : t_tm[2];
			tx_cm  <= (t_tm[1] < t_tm[3]) ? t_tm[1] : t_tm[3];
		end
	end

	logic hit_c;
	assign hit_c = ok_cm && !(te_cm > tx_cm);

	always_ff @(posedge clk) begin
		if (en) begin
			hit        <= hit_c;
			entry_time <= hit_c ? te_cm[TIME_FRAC:0] : '0;
			if (!hit_c) begin
				normal_x <= NRM_ZERO;
				normal_y <= NRM_ZERO;
			end else if (xgt_cm) begin
				normal_x <= ctl_cm.dx_pos ? NRM_NEG : NRM_POS;
				normal_y <= NRM_ZERO;
			end else begin
				normal_x <= NRM_ZERO;
				normal_y <= ctl_cm.dy_pos ? NRM_NEG : NRM_POS;
			end
		end
	end

	`SBC_ASSERT_IMP(a_miss_clear, res_valid && !hit,
		entry_time == '0 && normal_x == NRM_ZERO && normal_y == NRM_ZERO,
		"miss with nonzero fields")
	`SBC_ASSERT_IMP(a_time_range, res_valid && hit,
		entry_time <= TONE_T[TIME_FRAC:0], "entry time beyond one")
	`SBC_ASSERT_IMP(a_one_normal, res_valid && hit,
		(normal_x == NRM_ZERO) != (normal_y == NRM_ZERO), "hit needs one normal axis")
	`SBC_ASSERT_NXT(a_enter, item_valid && item_ready, vld_q[0], "accepted beat lost")

endmodule
`default_nettype wire
